/* src/ihl_pkg.sv */
// Shared types, codes and character helpers of the Intel HEX record loader.
package ihl_pkg;

    localparam int ADDRESS_BITS = 20;
    localparam int SUM_ADDR_W   = 21;
    localparam logic [SUM_ADDR_W-1:0] ADDR_MASK =
        SUM_ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_FORMAT = 3'd1;
    localparam logic [2:0] ERR_TYPE   = 3'd2;
    localparam logic [2:0] ERR_RANGE  = 3'd3;
    localparam logic [2:0] ERR_SUM    = 3'd4;

    localparam logic REG_ADDRESS_OFFSET = 1'b0;
    localparam logic REG_MEMORY_SIZE    = 1'b1;

    localparam logic [20:0] MEMORY_SIZE_RESET = 21'd65536;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_COLON,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef struct packed {
        logic [19:0] address_offset;
        logic [20:0] memory_size;
    } cfg_t;

    typedef struct packed {
        logic        write_valid;
        logic [19:0] write_address;
        logic [7:0]  write_data;
        logic        done_res;
        logic [2:0]  error_code;
        logic [23:0] bytes_loaded;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

/* src/ihl_cfg_regs.sv */
// Configuration registers of the loader behind an APB-style port.
module ihl_cfg_regs
    import ihl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [19:0] offset_reg;
    logic [20:0] size_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 20'd0;
            size_reg   <= MEMORY_SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_ADDRESS_OFFSET: offset_reg <= pwdata[19:0];
                REG_MEMORY_SIZE:    size_reg   <= pwdata[20:0];
                default:            offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ADDRESS_OFFSET: prdata = {12'd0, offset_reg};
            REG_MEMORY_SIZE:    prdata = {11'd0, size_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.address_offset = offset_reg;
    assign cfg.memory_size    = size_reg;

endmodule

/* src/ihl_parser.sv */
// Record parser: per-character state update and result computation.
module ihl_parser
    import ihl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] character,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t      phase_reg,   phase_next;
    logic [1:0]  dc_reg,      dc_next;
    logic [15:0] fv_reg,      fv_next;
    logic [7:0]  left_reg,    left_next;
    logic [16:0] raddr_reg,   raddr_next;
    logic        rtype_reg,   rtype_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [23:0] total_reg,   total_next;
    logic [2:0]  err_reg,     err_next;
    logic        fin_reg,     fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COLON;
            dc_reg    <= 2'd0;
            fv_reg    <= 16'd0;
            left_reg  <= 8'd0;
            raddr_reg <= 17'd0;
            rtype_reg <= 1'b0;
            sum_reg   <= 8'd0;
            total_reg <= 24'd0;
            err_reg   <= ERR_NONE;
            fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            dc_reg    <= dc_next;
            fv_reg    <= fv_next;
            left_reg  <= left_next;
            raddr_reg <= raddr_next;
            rtype_reg <= rtype_next;
            sum_reg   <= sum_next;
            total_reg <= total_next;
            err_reg   <= err_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin : step_logic
        logic [4:0]            hv;
        logic [2:0]            cnt;
        logic [2:0]            need;
        logic [15:0]           v;
        logic [SUM_ADDR_W-1:0] addr;
        logic                  wvalid;
        logic [19:0]           waddr;
        logic [7:0]            wdata;

        phase_next = phase_reg;
        dc_next    = dc_reg;
        fv_next    = fv_reg;
        left_next  = left_reg;
        raddr_next = raddr_reg;
        rtype_next = rtype_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        err_next   = err_reg;
        fin_next   = fin_reg;
        wvalid     = 1'b0;
        waddr      = 20'd0;
        wdata      = 8'd0;

        hv   = hex_value(character);
        cnt  = {1'b0, dc_reg} + 3'd1;
        need = (phase_reg == PH_ADDR) ? 3'd4 : 3'd2;
        v    = {fv_reg[11:0], hv[3:0]};
        addr = {4'd0, raddr_reg} + {1'b0, cfg.address_offset};

        if (err_reg == ERR_NONE && !fin_reg)
        begin
            if (phase_reg == PH_COLON)
            begin
                if (character == CHAR_COLON)
                begin
                    phase_next = PH_LEN;
                    dc_next    = 2'd0;
                    fv_next    = 16'd0;
                    sum_next   = 8'd0;
                end
                else if (!is_blank(character))
                begin
                    err_next = ERR_FORMAT;
                end
            end
            else if (!(dc_reg == 2'd0 && is_blank(character)))
            begin
                if (!hv[4])
                begin
                    err_next = ERR_FORMAT;
                end
                else
                begin
                    fv_next = v;
                    dc_next = cnt[1:0];
                    if (cnt >= need)
                    begin
                        // Field complete: consume it and clear the digit collector.
                        dc_next = 2'd0;
                        fv_next = 16'd0;
                        case (phase_reg)
                            PH_LEN:
                            begin
                                left_next  = v[7:0];
                                sum_next   = sum_reg + v[7:0];
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                raddr_next = {1'b0, v};
                                sum_next   = sum_reg + v[15:8] + v[7:0];
                                phase_next = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                if (v > 16'd1)
                                begin
                                    err_next = ERR_TYPE;
                                end
                                else
                                begin
                                    rtype_next = v[0];
                                    sum_next   = sum_reg + v[7:0];
                                    phase_next = (left_reg != 8'd0) ? PH_DATA : PH_SUM;
                                end
                            end
                            PH_DATA:
                            begin
                                if (addr >= cfg.memory_size || addr > ADDR_MASK)
                                begin
                                    err_next = ERR_RANGE;
                                end
                                else
                                begin
                                    wvalid     = 1'b1;
                                    waddr      = addr[19:0];
                                    wdata      = v[7:0];
                                    sum_next   = sum_reg + v[7:0];
                                    total_next = (total_reg != TOTAL_MAX) ?
                                                 total_reg + 24'd1 : total_reg;
                                    raddr_next = raddr_reg + 17'd1;
                                    left_next  = left_reg - 8'd1;
                                    if (left_reg == 8'd1)
                                    begin
                                        phase_next = PH_SUM;
                                    end
                                end
                            end
                            PH_SUM:
                            begin
                                sum_next = sum_reg + v[7:0];
                                if (sum_next != 8'd0)
                                begin
                                    err_next = ERR_SUM;
                                end
                                else
                                begin
                                    fin_next   = rtype_reg;
                                    phase_next = PH_COLON;
                                end
                            end
                            default:
                            begin
                                err_next = ERR_FORMAT;
                            end
                        endcase
                    end
                end
            end
        end

        result.write_valid   = wvalid;
        result.write_address = waddr;
        result.write_data    = wdata;
        result.done_res      = fin_next;
        result.error_code    = err_next;
        result.bytes_loaded  = total_next;
    end

    // A latched error never changes until reset.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("latched error code changed");

    // Done, once set, stays set.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> fin_reg)
        else $error("done flag dropped");

    // A data write goes out only while no error is raised and before done.
    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.write_valid |-> (result.error_code == ERR_NONE && !fin_reg
                                && phase_reg == PH_DATA))
        else $error("write issued outside a clean data field");

    // The loaded byte count only grows.
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("byte count decreased");

endmodule

/* src/ihl_out_buf.sv */
// Two-entry result buffer: output register with a skid stage behind it.
module ihl_out_buf
    import ihl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

/* src/intel_hex_record_loader_unit.sv */
// Top level of the Intel HEX record loader: config port, parser and result buffer.
//
// The loader takes one ASCII character per input beat and returns exactly one
// result beat per character, carrying an optional memory write (address and
// byte) plus the running status: done, latched error code and a saturating
// count of stored bytes. One character is taken in every clock cycle while
// the result buffer has a free entry; the parser's update of its field,
// checksum and address registers holds the whole per-character step. A result
// beat is registered at the same edge that takes its character: in the output
// register, offered from the next cycle on, if that is free or being emptied,
// else in the skid entry. The two-entry result buffer lets input continue while
// one result waits under stall; input stalls only when both entries hold
// untaken results. After the end-of-file record or the first error, further
// characters are still taken and answered with the frozen status and no write.
// Write address_offset and memory_size only while no result is outstanding.
module intel_hex_record_loader_unit
    import ihl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // character input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_valid,
    output logic [19:0] write_address,
    output logic [7:0]  write_data,
    output logic        done_res,
    output logic [2:0]  error_code,
    output logic [23:0] bytes_loaded
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    buf_full;
    logic    in_accept;

    // Take a character beat whenever the result buffer has a free entry.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    ihl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the parser state on every accepted beat; its result is pushed
    // into the buffer in the same cycle.
    ihl_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .character (character),
        .cfg       (cfg),
        .result    (step_result)
    );

    // Hold results until the downstream side takes them.
    ihl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign write_valid   = out_data.write_valid;
    assign write_address = out_data.write_address;
    assign write_data    = out_data.write_data;
    assign done_res      = out_data.done_res;
    assign error_code    = out_data.error_code;
    assign bytes_loaded  = out_data.bytes_loaded;

endmodule
